// ===== src/med_pkg.sv =====
// ----------------------------------------------------------------------------
// med_pkg: shared types and constants of the 3x3 median filter
// Job record passed from the front end to the sorting back end, register map.
// ----------------------------------------------------------------------------
package med_pkg;

    // 3x3 window, row-major: index row*3+col, rows oldest first
    typedef logic [8:0][7:0] t_win;

    // One result to compute: window picked from clamped rows and columns
    typedef struct packed {
        t_win        win;
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic        frame_done;
        logic        last;
    } t_job;

    // Register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BORDER_ROWS  = 2'd2,
        REG_NONE         = 2'd3
    } t_reg_idx;

    localparam int QDEPTH = 4;

endpackage

// ===== src/med_pix_if.sv =====
// ----------------------------------------------------------------------------
// med_pix_if: pixel input channel
// Valid/ready stream carrying one 8-bit pixel per transfer.
// ----------------------------------------------------------------------------
interface med_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== src/med_res_if.sv =====
// ----------------------------------------------------------------------------
// med_res_if: median result channel
// Valid/ready stream carrying one filtered pixel and its position per transfer.
// ----------------------------------------------------------------------------
interface med_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  median;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        frame_done;
    logic        last;

    modport source (output valid, output median, output out_row, output out_col,
                    output frame_done, output last, input ready);
    modport sink   (input valid, input median, input out_row, input out_col,
                    input frame_done, input last, output ready);
endinterface

// ===== src/median3x3_image_filter_unit.sv =====
// ----------------------------------------------------------------------------
// median3x3_image_filter_unit: streaming 3x3 median filter
// Raster-order 8-bit pixels in, edge-clamped 3x3 medians with coordinates out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_pix     in   valid/ready        pixel[7:0]
//  o_res     out  valid/ready        median, out_row, out_col, frame_done, last
//  apb       in   psel/penable/...   frame_width, frame_height, border_rows
//
//  One pixel per cycle while no pending jobs hold intake; from pixel transfer
//  to result: store read, classify, queue, two sort stages, output register.
//  A pixel may cause up to four results; the job issuer emits one per cycle
//  while the queue accepts, so intake holds at row ends and on the last row.
//  A full job queue or a held output stalls only its own side.
//  Synchronous active-low reset clears counters, window and all valid state;
//  the line store needs no clearing: no result uses an entry before its write.
// ----------------------------------------------------------------------------
module median3x3_image_filter_unit
    import med_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    med_pix_if.sink     i_pix,
    med_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);

    // configuration registers
    logic [11:0] r_fw;
    logic [12:0] r_fh;
    logic [11:0] r_br;
    logic        wr_en;
    t_reg_idx    idx;

    // clamped sizes
    logic [WW-1:0] w;
    logic [HW-1:0] h;

    // queue links
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    t_job q_in_job, q_out_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = 32'(r_fw);
            REG_FRAME_HEIGHT: prdata = 32'(r_fh);
            REG_BORDER_ROWS:  prdata = 32'(r_br);
            default:          prdata = '0;
        endcase
    end

    // hold registers; writes beyond the list drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 12'd640;
            r_fh <= 13'd480;
            r_br <= 12'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_FRAME_WIDTH:  r_fw <= pwdata[11:0];
                REG_FRAME_HEIGHT: r_fh <= pwdata[12:0];
                REG_BORDER_ROWS:  r_br <= pwdata[11:0];
                default:          ;
            endcase
        end
    end

    // clamp sizes to 1..MAX
    always_comb begin
        if (r_fw == '0)                 w = WW'(1);
        else if (int'(r_fw) > MAX_WIDTH) w = WW'(MAX_WIDTH);
        else                            w = WW'(r_fw);
        if (r_fh == '0)                  h = HW'(1);
        else if (int'(r_fh) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
        else                             h = HW'(r_fh);
    end

    // front end: intake, line store, window, job issue
    med_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (w),
        .i_h         (h),
        .i_b         (r_br),
        .i_valid     (i_pix.valid),
        .o_ready     (i_pix.ready),
        .i_pixel     (i_pix.pixel),
        .o_job_valid (q_in_valid),
        .i_job_ready (q_in_ready),
        .o_job       (q_in_job)
    );

    // job queue decouples issue from sorting
    med_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_in_valid),
        .o_ready (q_in_ready),
        .i_job   (q_in_job),
        .o_valid (q_out_valid),
        .i_ready (q_out_ready),
        .o_job   (q_out_job)
    );

    // back end: sorting network and output register
    med_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_out_valid),
        .o_ready (q_out_ready),
        .i_job   (q_out_job),
        .o_res   (o_res)
    );

    // the frame's final target is always the last result of its pixel
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_done |-> o_res.last)
        else $error("frame_done without last");

    // no result appears right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid after reset");

    // a job offered to a full queue is never lost
    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_in_valid && !q_in_ready |=> q_in_valid)
        else $error("job dropped at full queue");
endmodule

// ===== src/med_front.sv =====
// ----------------------------------------------------------------------------
// med_front: pixel intake, line stores, window and job classification
// Tracks position, reads/writes the line store, shifts the window and issues
// up to four jobs per pixel, one per cycle while the job queue accepts.
// ----------------------------------------------------------------------------
module med_front
    import med_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_h,
    input  logic [11:0]                       i_b,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_pixel,
    output logic                              o_job_valid,
    input  logic                              i_job_ready,
    output t_job                              o_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int XW = ((HW > 12) ? HW : 12) + 2;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] c_acc;
    logic [RW-1:0] r_acc;
    logic [CW:0]   c_inc;
    logic [RW:0]   r_inc;
    logic          accept;

    // stage B: pixel plus line store read
    logic          r_b_valid;
    logic [7:0]    r_b_px;
    logic [CW-1:0] r_b_col;
    logic [RW-1:0] r_b_row;
    logic [15:0]   r_rd;
    logic          r_byp;
    logic [15:0]   r_bypd;
    logic [15:0]   up_eff;
    logic [15:0]   r_mem [MAX_WIDTH];

    // stage C: window and pending jobs
    t_win          r_win;
    logic [3:0]    r_mask;
    logic [CW-1:0] r_c_col;
    logic [RW-1:0] r_c_row;

    logic          move, emit, c_done, last_job;
    logic [3:0]    sel;
    logic [3:0]    n_mask;
    logic          tok0, tok1;
    logic [XW-1:0] bx, hx, rbx;

    assign c_acc  = (WW'(r_col) >= i_w) ? '0 : r_col;
    assign r_acc  = (HW'(r_row) >= i_h) ? '0 : r_row;
    assign c_inc  = {1'b0, c_acc} + 1'b1;
    assign r_inc  = {1'b0, r_acc} + 1'b1;
    assign accept = i_valid && o_ready;
    assign up_eff = r_byp ? r_bypd : r_rd;

    // classify the pixel in stage B
    assign bx  = XW'(i_b);
    assign hx  = XW'(i_h);
    assign rbx = XW'(r_b_row);
    always_comb begin
        tok0 = (rbx >= XW'(1)) && (rbx - XW'(1) >= bx) && (rbx + bx <= hx);
        tok1 = (rbx == hx - XW'(1)) && (rbx >= bx) && (rbx + bx + XW'(1) <= hx);
        n_mask[0] = tok0 && (r_b_col != '0);
        n_mask[1] = tok0 && (WW'(r_b_col) == i_w - WW'(1));
        n_mask[2] = tok1 && (r_b_col != '0);
        n_mask[3] = tok1 && (WW'(r_b_col) == i_w - WW'(1));
    end

    // lowest pending job first: row r-1 before r, column c-1 before c
    always_comb begin
        priority if (r_mask[0]) sel = 4'b0001;
        else if (r_mask[1])     sel = 4'b0010;
        else if (r_mask[2])     sel = 4'b0100;
        else                    sel = 4'b1000;
    end

    assign last_job    = (r_mask & ~sel) == 4'b0000;
    assign o_job_valid = r_mask != 4'b0000;
    assign emit        = o_job_valid && i_job_ready;
    assign c_done      = (r_mask == 4'b0000) || (emit && last_job);
    assign move        = r_b_valid && c_done;
    assign o_ready     = !r_b_valid || move;

    // build the job for the selected target
    always_comb begin
        logic          tr, uc;
        logic [1:0]    rs [3];
        logic [1:0]    cs [3];
        logic [RW-1:0] t;
        logic [CW-1:0] u;
        logic [XW-1:0] tx;
        tr = sel[2] || sel[3];
        uc = sel[1] || sel[3];
        t  = tr ? r_c_row : r_c_row - RW'(1);
        u  = uc ? r_c_col : r_c_col - CW'(1);
        tx = XW'(t);
        if (tr) begin
            rs[0] = (r_c_row != '0) ? 2'd1 : 2'd2;
            rs[1] = 2'd2;
        end else begin
            rs[0] = (r_c_row >= RW'(2)) ? 2'd0 : 2'd1;
            rs[1] = 2'd1;
        end
        rs[2] = 2'd2;
        if (uc) begin
            cs[0] = (r_c_col != '0) ? 2'd1 : 2'd2;
            cs[1] = 2'd2;
        end else begin
            cs[0] = (r_c_col >= CW'(2)) ? 2'd0 : 2'd1;
            cs[1] = 2'd1;
        end
        cs[2] = 2'd2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                o_job.win[i*3+j] = r_win[4'(rs[i]) * 4'd3 + 4'(cs[j])];
            end
        end
        o_job.out_row    = 12'(tx - bx);
        o_job.out_col    = 11'(u);
        o_job.frame_done = (tx + bx + XW'(1) == hx) && (WW'(u) == i_w - WW'(1));
        o_job.last       = last_job;
    end

    // line store: {row r-2, row r-1} per column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[c_acc];
        end
        if (move) begin
            r_mem[r_b_col] <= {up_eff[7:0], r_b_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_px  <= i_pixel;
            r_b_col <= c_acc;
            r_b_row <= r_acc;
            // forward a write to the same column landing this cycle
            r_byp   <= move && (r_b_col == c_acc);
            r_bypd  <= {up_eff[7:0], r_b_px};
        end
        if (move) begin
            r_c_col <= r_b_col;
            r_c_row <= r_b_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_mask    <= '0;
            r_win     <= '0;
        end else begin
            if (accept) begin
                if ((CW+1)'(i_w) <= c_inc) begin
                    r_col <= '0;
                    r_row <= ((RW+1)'(i_h) <= r_inc) ? '0 : r_inc[RW-1:0];
                end else begin
                    r_col <= c_inc[CW-1:0];
                    r_row <= r_acc;
                end
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (move) begin
                r_b_valid <= 1'b0;
            end
            if (move) begin
                r_mask <= n_mask;
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= up_eff[15:8];
                r_win[5] <= up_eff[7:0];
                r_win[8] <= r_b_px;
            end else if (emit) begin
                r_mask <= r_mask & ~sel;
            end
        end
    end
endmodule

// ===== src/med_fifo.sv =====
// ----------------------------------------------------------------------------
// med_fifo: job queue between front and back end
// Small register queue so that classification and sorting stall on their own.
// ----------------------------------------------------------------------------
module med_fifo
    import med_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    localparam int AW = $clog2(QDEPTH);

    t_job              r_q [QDEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              push, pop;

    assign o_ready = r_cnt != (AW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== src/med_back.sv =====
// ----------------------------------------------------------------------------
// med_back: median sorting network
// Nineteen compare-exchange steps over two pipeline stages and an output
// register; the whole pipe holds while a result waits.
// ----------------------------------------------------------------------------
module med_back
    import med_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    med_res_if.source o_res
);
    function automatic t_win ord(t_win v, logic [3:0] i, logic [3:0] j);
        t_win       w;
        logic [7:0] s;
        w = v;
        if (w[i] > w[j]) begin
            s    = w[i];
            w[i] = w[j];
            w[j] = s;
        end
        return w;
    endfunction

    logic r_s1v, r_s2v, r_ov;
    t_job r_s1, r_s2;
    t_win w1, w2, w3;
    logic en;

    assign en      = !r_ov || o_res.ready;
    assign o_ready = en;

    always_comb begin
        w1 = i_job.win;
        w1 = ord(w1, 4'd1, 4'd2); w1 = ord(w1, 4'd4, 4'd5); w1 = ord(w1, 4'd7, 4'd8);
        w1 = ord(w1, 4'd0, 4'd1); w1 = ord(w1, 4'd3, 4'd4); w1 = ord(w1, 4'd6, 4'd7);
        w1 = ord(w1, 4'd1, 4'd2); w1 = ord(w1, 4'd4, 4'd5); w1 = ord(w1, 4'd7, 4'd8);
    end

    always_comb begin
        w2 = r_s1.win;
        w2 = ord(w2, 4'd0, 4'd3); w2 = ord(w2, 4'd5, 4'd8); w2 = ord(w2, 4'd4, 4'd7);
        w2 = ord(w2, 4'd3, 4'd6); w2 = ord(w2, 4'd1, 4'd4); w2 = ord(w2, 4'd2, 4'd5);
    end

    always_comb begin
        w3 = r_s2.win;
        w3 = ord(w3, 4'd4, 4'd7); w3 = ord(w3, 4'd4, 4'd2);
        w3 = ord(w3, 4'd6, 4'd4); w3 = ord(w3, 4'd4, 4'd2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= {w1, i_job.out_row, i_job.out_col, i_job.frame_done, i_job.last};
            r_s2 <= {w2, r_s1.out_row, r_s1.out_col, r_s1.frame_done, r_s1.last};
            if (r_s2v) begin
                o_res.median     <= w3[4];
                o_res.out_row    <= r_s2.out_row;
                o_res.out_col    <= r_s2.out_col;
                o_res.frame_done <= r_s2.frame_done;
                o_res.last       <= r_s2.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_s1v <= i_valid;
            r_s2v <= r_s1v;
            r_ov  <= r_s2v;
        end
    end

    assign o_res.valid = r_ov;
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 median filter
// Streams whole frames of raster pixels over several geometries, predicts the
// edge-clamped medians with coordinates and flags, and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import med_pkg::*;

    // Result record as the bench predicts it
    typedef struct {
        logic [7:0]  median;
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic        frame_done;
        logic        last;
    } t_med_res;

    // Pixel content styles of a frame
    typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_FLAT} t_pix_style;

    localparam int MAXW = 2048;
    localparam int MAXH = 4096;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    med_pix_if pix ();
    med_res_if res ();

    median3x3_image_filter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the filter state
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] border_reg;
    logic [7:0]  row_m2 [MAXW];    // line two rows up
    logic [7:0]  row_m1 [MAXW];    // line one row up
    logic [7:0]  win [9];          // rows r-2,r-1,r by columns c-2,c-1,c
    int          row_pos;
    int          col_pos;

    logic [7:0]  pixel_q [$];      // pixels waiting to be sent
    t_med_res    median_q [$];     // medians expected, oldest first

    int  err_cnt;
    int  pix_sent;
    int  med_seen;
    int  frame_cnt;
    bit  calm;                     // no idling on either side
    bit  hold_tx;                  // sender paused
    int  tx_gap;
    int  rx_stall;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] mid_of_nine(logic [7:0] v [9]);
        logic [7:0] s [9];
        logic [7:0] key;
        int j;
        s = v;
        for (int i = 1; i < 9; i++) begin
            key = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > key) begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = key;
        end
        return s[4];
    endfunction

    function automatic int eff_width();
        return (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : int'(width_reg));
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : ((height_reg > MAXH) ? MAXH : int'(height_reg));
    endfunction

    // Advance the window by one pixel and queue the medians it completes
    function automatic void filter_pixel(logic [7:0] px);
        int w, h, b, r, c, t, u;
        int rs [3];
        int cs [3];
        logic [7:0] v [9];
        t_med_res rec;
        t_med_res found [$];
        w = eff_width();
        h = eff_height();
        b = border_reg;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = row_m2[c];
        win[5] = row_m1[c];
        win[8] = px;
        row_m2[c] = row_m1[c];
        row_m1[c] = px;
        for (int tr = 0; tr < 2; tr++) begin
            if (tr == 0) begin
                if (r < 1) continue;
                t = r - 1;
                rs = '{(t > 0) ? 0 : 1, 1, 2};
            end else begin
                if (r != h - 1) continue;
                t = r;
                rs = '{(t > 0) ? 1 : 2, 2, 2};
            end
            // skip border rows at top and bottom
            if (t < b || t + b + 1 > h) continue;
            for (int uc = 0; uc < 2; uc++) begin
                if (uc == 0) begin
                    if (c < 1) continue;
                    u = c - 1;
                    cs = '{(u > 0) ? 0 : 1, 1, 2};
                end else begin
                    if (c != w - 1) continue;
                    u = c;
                    cs = '{(u > 0) ? 1 : 2, 2, 2};
                end
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        v[i*3 + j] = win[rs[i]*3 + cs[j]];
                rec.median     = mid_of_nine(v);
                rec.out_row    = 12'(t - b);
                rec.out_col    = 11'(u);
                rec.frame_done = (t + b + 1 == h) && (u == w - 1);
                rec.last       = 1'b0;
                found.push_back(rec);
            end
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) median_q.push_back(found[i]);
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pixel driver: pop from the pending queue, insert idle bursts
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            tx_gap    <= 0;
        end else begin
            if (pix.valid && pix.ready) begin
                filter_pixel(pix.pixel);
                pix_sent <= pix_sent + 1;
            end
            if (pix.valid && !pix.ready) begin
                // hold the current transfer
            end else if (tx_gap > 0 && !calm) begin
                pix.valid <= 1'b0;
                tx_gap    <= tx_gap - 1;
            end else if (!hold_tx && pixel_q.size() > 0) begin
                pix.valid <= 1'b1;
                pix.pixel <= pixel_q.pop_front();
                if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 15);
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_med_res exp_r;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            rx_stall  <= 0;
        end else begin
            if (res.valid && res.ready) begin
                med_seen <= med_seen + 1;
                if (median_q.size() == 0) begin
                    $error("unexpected result row %0d col %0d", res.out_row, res.out_col);
                    err_cnt++;
                end else begin
                    exp_r = median_q.pop_front();
                    if (res.median !== exp_r.median) begin
                        $error("median exp %0d got %0d", exp_r.median, res.median);
                        err_cnt++;
                    end
                    if (res.out_row !== exp_r.out_row) begin
                        $error("out_row exp %0d got %0d", exp_r.out_row, res.out_row);
                        err_cnt++;
                    end
                    if (res.out_col !== exp_r.out_col) begin
                        $error("out_col exp %0d got %0d", exp_r.out_col, res.out_col);
                        err_cnt++;
                    end
                    if (res.frame_done !== exp_r.frame_done) begin
                        $error("frame_done exp %0b got %0b", exp_r.frame_done,
                               res.frame_done);
                        err_cnt++;
                    end
                    if (res.last !== exp_r.last) begin
                        $error("last exp %0b got %0b", exp_r.last, res.last);
                        err_cnt++;
                    end
                end
            end
            // stall in bursts; drop stalls entirely in the calm tail
            if (calm) begin
                res.ready <= 1'b1;
                rx_stall  <= 0;
            end else if (rx_stall > 0) begin
                res.ready <= 1'b0;
                rx_stall  <= rx_stall - 1;
            end else if ($urandom_range(0, 11) == 0) begin
                res.ready <= 1'b0;
                rx_stall  <= $urandom_range(0, 14);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register access: setup then access cycle, read back afterwards
    // ------------------------------------------------------------------------
    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register takes the value at this edge
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = val[11:0];
            REG_FRAME_HEIGHT: height_reg = val[12:0];
            REG_BORDER_ROWS:  border_reg = val[11:0];
            default: ;
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  if (prdata[11:0] !== width_reg) begin
                $error("frame_width read exp %0d got %0d", width_reg, prdata[11:0]);
                err_cnt++;
            end
            REG_FRAME_HEIGHT: if (prdata[12:0] !== height_reg) begin
                $error("frame_height read exp %0d got %0d", height_reg, prdata[12:0]);
                err_cnt++;
            end
            REG_BORDER_ROWS:  if (prdata[11:0] !== border_reg) begin
                $error("border_rows read exp %0d got %0d", border_reg, prdata[11:0]);
                err_cnt++;
            end
            default: ;
        endcase
    endtask

    // Wait until every queued pixel is sent and every median has arrived,
    // then let the pipeline drain results that rows in the border never make
    task automatic drain();
        while (pixel_q.size() > 0 || pix.valid || median_q.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Reconfigure at a frame boundary and stream one frame, or only its first
    // max_pix pixels when max_pix is nonzero
    task automatic run_frame(logic [31:0] w_val, logic [31:0] h_val, logic [31:0] b_val,
                             t_pix_style style, bit pause_mid, int max_pix = 0);
        int n;
        logic [7:0] flat;
        drain();
        reg_write(REG_FRAME_WIDTH, w_val);
        reg_write(REG_FRAME_HEIGHT, h_val);
        reg_write(REG_BORDER_ROWS, b_val);
        n = eff_width() * eff_height();
        if (max_pix > 0 && max_pix < n) n = max_pix;
        flat = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            case (style)
                PIX_EXTREME: pixel_q.push_back(((i + i / eff_width()) % 2) ? 8'hFF : 8'h00);
                PIX_FLAT:    pixel_q.push_back(flat);
                default:     pixel_q.push_back(($urandom_range(0, 5) == 0) ?
                                               (($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00)
                                               : 8'($urandom));
            endcase
        end
        if (pause_mid) begin
            // stop sending halfway and let every expected median come out
            while (pixel_q.size() > n / 2) @(posedge i_clk);
            @(posedge i_clk);
            hold_tx <= 1'b1;
            while (pix.valid || median_q.size() > 0) @(posedge i_clk);
            hold_tx <= 1'b0;
        end
        frame_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int w, h;
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        res.ready = 1'b0;
        err_cnt   = 0;
        pix_sent  = 0;
        med_seen  = 0;
        frame_cnt = 0;
        calm      = 1'b0;
        hold_tx   = 1'b0;
        width_reg  = 12'd640;
        height_reg = 13'd480;
        border_reg = 12'd0;
        row_pos = 0;
        col_pos = 0;
        foreach (win[i]) win[i] = '0;
        foreach (row_m2[i]) begin
            row_m2[i] = '0;
            row_m1[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single pixel, zero sizes, borders
        run_frame(3, 3, 0, PIX_EXTREME, 1'b0);
        run_frame(1, 1, 0, PIX_RANDOM, 1'b0);
        run_frame(0, 0, 0, PIX_FLAT, 1'b0);
        run_frame(2, 4, 1, PIX_RANDOM, 1'b0);
        run_frame(3, 2, 1, PIX_RANDOM, 1'b0);      // border too large

        // random frames, small sizes
        while (pix_sent + pixel_q.size() < 200) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            run_frame(w, h, $urandom_range(0, 3),
                      ($urandom_range(0, 7) == 0) ? PIX_FLAT : PIX_RANDOM,
                      frame_cnt == 7);
        end

        // a few large and out-of-range geometries, leading part of the frame only
        run_frame(32'hFFFF_FFFF, 2, 0, PIX_RANDOM, 1'b0, 32);   // width clamps to maximum
        run_frame(1, 32'hFFFF_FFFF, 2047, PIX_RANDOM, 1'b0, 24); // height clamps to maximum
        run_frame(2048, 1, 0, PIX_EXTREME, 1'b0, 32);
        run_frame(1, 4096, 0, PIX_RANDOM, 1'b0, 24);
        run_frame(4, 4, 32'hFFFF_FFFF, PIX_RANDOM, 1'b0);    // border masks to maximum

        // tail without idling
        drain();
        calm = 1'b1;
        while (pix_sent + pixel_q.size() < 430) begin
            run_frame($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 2),
                      PIX_RANDOM, 1'b0);
        end
        drain();

        $display("covered %0d frames, %0d pixels, %0d medians checked",
                 frame_cnt, pix_sent, med_seen);
        $display("sizes from 1x1 to clamped maxima, borders from none to oversized");
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------------
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
